>>> hdl/ssd_pkg.sv
// shared constants, types and lookup functions of the scrolling seven-segment driver
package ssd_pkg;

    localparam int BUF_DEPTH = 32;
    localparam int DIGITS    = 4;

    localparam int ADDR_W   = $clog2(BUF_DEPTH);
    localparam int CNT_W    = $clog2(BUF_DEPTH + 1);
    localparam int WIN_W    = CNT_W + 1;
    localparam int PHASE_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam int GLYPH_W  = 6;
    localparam int SEG_W    = 8;
    localparam int ENA_W    = 4;
    localparam int CHAR_W   = 8;
    localparam int PERIOD_W = 8;

    localparam logic [PERIOD_W-1:0] SCROLL_PERIOD_RST = PERIOD_W'(50);

    // request kinds
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

    typedef logic [GLYPH_W-1:0] glyph_t;

    // glyph codes, in segment table order
    localparam glyph_t GLYPH_BLANK      = 6'd0;
    localparam glyph_t GLYPH_DIGIT0     = 6'd1;
    localparam glyph_t GLYPH_A          = 6'd11;
    localparam glyph_t GLYPH_L          = 6'd21;
    localparam glyph_t GLYPH_M_LEFT     = 6'd22;
    localparam glyph_t GLYPH_M_RIGHT    = 6'd23;
    localparam glyph_t GLYPH_N          = 6'd24;
    localparam glyph_t GLYPH_W_LEFT     = 6'd32;
    localparam glyph_t GLYPH_W_RIGHT    = 6'd33;
    localparam glyph_t GLYPH_X_LEFT     = 6'd34;
    localparam glyph_t GLYPH_X_RIGHT    = 6'd35;
    localparam glyph_t GLYPH_Y          = 6'd36;
    localparam glyph_t GLYPH_DOT        = 6'd37;
    localparam glyph_t GLYPH_MINUS      = 6'd38;
    localparam glyph_t GLYPH_UNDERSCORE = 6'd39;

    typedef struct packed {
        logic   pair;
        glyph_t left_g;
        glyph_t right_g;
    } glyph_pair_t;

    typedef struct packed {
        logic             loading;
        logic [CNT_W-1:0] glyph_count;
    } store_stat_t;

    // ascii to one glyph, or two for the wide letters
    function automatic glyph_pair_t char_to_glyph(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] lc;
        logic [CHAR_W-1:0] ofs;
        glyph_pair_t       r;
        lc = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            lc = c + 8'h20;
        end
        r.pair    = 1'b0;
        r.left_g  = GLYPH_BLANK;
        r.right_g = GLYPH_BLANK;
        ofs       = 8'h00;
        if (lc >= 8'h30 && lc <= 8'h39)
        begin
            ofs      = lc - 8'h30;
            r.left_g = GLYPH_DIGIT0 + ofs[GLYPH_W-1:0];
        end
        else if (lc >= 8'h61 && lc <= 8'h6A)
        begin
            ofs      = lc - 8'h61;
            r.left_g = GLYPH_A + ofs[GLYPH_W-1:0];
        end
        else if (lc >= 8'h6E && lc <= 8'h75)
        begin
            ofs      = lc - 8'h6E;
            r.left_g = GLYPH_N + ofs[GLYPH_W-1:0];
        end
        else if (lc == 8'h6C)
        begin
            r.left_g = GLYPH_L;
        end
        else if (lc == 8'h79)
        begin
            r.left_g = GLYPH_Y;
        end
        else if (lc == 8'h2E)
        begin
            r.left_g = GLYPH_DOT;
        end
        else if (lc == 8'h2D)
        begin
            r.left_g = GLYPH_MINUS;
        end
        else if (lc == 8'h5F)
        begin
            r.left_g = GLYPH_UNDERSCORE;
        end
        else if (lc == 8'h6D)
        begin
            r.pair    = 1'b1;
            r.left_g  = GLYPH_M_LEFT;
            r.right_g = GLYPH_M_RIGHT;
        end
        else if (lc == 8'h77)
        begin
            r.pair    = 1'b1;
            r.left_g  = GLYPH_W_LEFT;
            r.right_g = GLYPH_W_RIGHT;
        end
        else if (lc == 8'h78)
        begin
            r.pair    = 1'b1;
            r.left_g  = GLYPH_X_LEFT;
            r.right_g = GLYPH_X_RIGHT;
        end
        return r;
    endfunction

    // segment pattern, bit0 a .. bit6 g, bit7 dot
    function automatic logic [SEG_W-1:0] seg_lookup(input glyph_t g);
        logic [SEG_W-1:0] s;
        case (g)
            6'd0:    s = 8'h00;
            6'd1:    s = 8'h3F;
            6'd2:    s = 8'h06;
            6'd3:    s = 8'h5B;
            6'd4:    s = 8'h4F;
            6'd5:    s = 8'h66;
            6'd6:    s = 8'h6D;
            6'd7:    s = 8'h7D;
            6'd8:    s = 8'h07;
            6'd9:    s = 8'h7F;
            6'd10:   s = 8'h67;
            6'd11:   s = 8'h77;
            6'd12:   s = 8'h7C;
            6'd13:   s = 8'h58;
            6'd14:   s = 8'h5E;
            6'd15:   s = 8'h79;
            6'd16:   s = 8'h71;
            6'd17:   s = 8'h6F;
            6'd18:   s = 8'h76;
            6'd19:   s = 8'h04;
            6'd20:   s = 8'h0E;
            6'd21:   s = 8'h38;
            6'd22:   s = 8'h33;
            6'd23:   s = 8'h27;
            6'd24:   s = 8'h54;
            6'd25:   s = 8'h5C;
            6'd26:   s = 8'h73;
            6'd27:   s = 8'hE7;
            6'd28:   s = 8'h50;
            6'd29:   s = 8'h6D;
            6'd30:   s = 8'h78;
            6'd31:   s = 8'h1C;
            6'd32:   s = 8'h3C;
            6'd33:   s = 8'h1E;
            6'd34:   s = 8'h4C;
            6'd35:   s = 8'h58;
            6'd36:   s = 8'h6E;
            6'd37:   s = 8'h80;
            6'd38:   s = 8'h40;
            6'd39:   s = 8'h08;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

>>> hdl/ssd_req_if.sv
// request channel: load character or multiplex tick
interface ssd_req_if
    import ssd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic              first;

    modport source (output valid, output req_type, output char_code, output first,
                    input ready);
    modport sink   (input valid, input req_type, input char_code, input first,
                    output ready);
endinterface

>>> hdl/ssd_res_if.sv
// result channel: segment pattern and digit selects
interface ssd_res_if
    import ssd_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SEG_W-1:0] segments;
    logic [ENA_W-1:0] digit_enable_n;

    modport source (output valid, output segments, output digit_enable_n, input ready);
    modport sink   (input valid, input segments, input digit_enable_n, output ready);
endinterface

>>> hdl/ssd_glyph_store.sv
// glyph buffer with string load control
module ssd_glyph_store
    import ssd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic              first,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [ADDR_W-1:0] rd_addr,
    output glyph_t            rd_glyph,
    output store_stat_t       stat
);

    glyph_t           glyph_mem_reg [BUF_DEPTH];
    logic [CNT_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             loading_reg, loading_next;

    logic             take;
    logic             is_end;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] base_inc;
    logic             we0, we1;
    glyph_pair_t      gp;

    assign gp       = char_to_glyph(char_code);
    assign take     = load_en && (first || loading_reg);
    assign is_end   = (char_code == CHAR_NUL);
    assign base     = first ? '0 : wp_reg;
    assign base_inc = base + CNT_W'(1);
    // dropped when past the end, right half included
    assign we0      = take && !is_end && (base < CNT_W'(BUF_DEPTH));
    assign we1      = we0 && gp.pair && (base_inc < CNT_W'(BUF_DEPTH));

    always_comb
    begin
        wp_next      = wp_reg;
        count_next   = count_reg;
        loading_next = loading_reg;
        if (take)
        begin
            if (is_end)
            begin
                wp_next      = base;
                count_next   = base;
                loading_next = 1'b0;
            end
            else
            begin
                wp_next      = base + CNT_W'(we0) + CNT_W'(we1);
                loading_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            count_reg   <= '0;
            loading_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            loading_reg <= loading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < BUF_DEPTH; i++)
        begin
            if (we0 && base == CNT_W'(i))
            begin
                glyph_mem_reg[i] <= gp.left_g;
            end
            else if (we1 && base_inc == CNT_W'(i))
            begin
                glyph_mem_reg[i] <= gp.right_g;
            end
        end
    end

    assign rd_glyph         = glyph_mem_reg[rd_addr];
    assign stat.loading     = loading_reg;
    assign stat.glyph_count = count_reg;

endmodule

>>> hdl/ssd_scan.sv
// digit multiplexing and scroll window control
module ssd_scan
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_en,
    input  logic [PERIOD_W-1:0] period,
    input  store_stat_t         stat,
    output logic [ADDR_W-1:0]   rd_addr,
    input  glyph_t              rd_glyph,
    output logic [SEG_W-1:0]    segments_next,
    output logic [ENA_W-1:0]    enable_n_next
);

    localparam logic signed [WIN_W-1:0] WIN_WRAP = WIN_W'(-DIGITS);

    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic signed [WIN_W-1:0]  win_reg, win_next;
    logic [PERIOD_W-1:0]      scan_reg, scan_next;
    logic [SEG_W-1:0]         hold_reg, hold_next;

    logic signed [WIN_W-1:0]  pos;
    logic signed [WIN_W-1:0]  win_inc;
    logic signed [WIN_W-1:0]  cnt_s;
    logic [PERIOD_W-1:0]      scan_inc;
    logic                     lit;
    logic                     end_scan;

    assign pos      = win_reg + $signed({{(WIN_W-PHASE_W){1'b0}}, phase_reg});
    assign lit      = !pos[WIN_W-1] && (pos[CNT_W-1:0] < stat.glyph_count);
    assign rd_addr  = pos[ADDR_W-1:0];
    assign end_scan = (phase_reg == PHASE_W'(DIGITS - 1));
    assign win_inc  = win_reg + WIN_W'(1);
    assign cnt_s    = $signed({1'b0, stat.glyph_count});
    assign scan_inc = scan_reg + PERIOD_W'(1);

    assign hold_next     = lit ? seg_lookup(rd_glyph) : hold_reg;
    assign segments_next = hold_next;

    always_comb
    begin
        for (int i = 0; i < ENA_W; i++)
        begin
            enable_n_next[i] = (i < DIGITS) && !(lit && phase_reg == PHASE_W'(i));
        end
    end

    always_comb
    begin
        phase_next = phase_reg + PHASE_W'(1);
        win_next   = win_reg;
        scan_next  = scan_reg;
        if (end_scan)
        begin
            phase_next = '0;
            if (stat.glyph_count > CNT_W'(DIGITS))
            begin
                scan_next = scan_inc;
                if (scan_inc >= period)
                begin
                    scan_next = '0;
                    win_next  = (win_inc >= cnt_s) ? WIN_WRAP : win_inc;
                end
            end
            else
            begin
                win_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            win_reg   <= '0;
            scan_reg  <= '0;
            hold_reg  <= '0;
        end
        else if (tick_en)
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            scan_reg  <= scan_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

>>> hdl/scrolling_seven_segment_driver_top.sv
// top level of the scrolling seven-segment driver
//
// requests come in on req: a load request (req_type 0) carries one ascii
// character, first set starts a new string and a nul character ends it; each
// character becomes one glyph (two for m, w and x) in a 32-slot buffer, and
// glyphs past the end are dropped. a tick request (req_type 1) lights the next
// of four active-low digits and returns one result on res; while a string is
// still loading a tick returns nothing. with more than four glyphs held the
// window moves one glyph after scroll_period full scans (written through
// cfg_wr_en / cfg_wr_data, reset value 50) and re-enters from the right.
// throughput is one request per clock, except that a tick which yields a
// result stalls while the output register holds a result and res.ready is
// low. a request is held in the input register and its result is captured in
// the output register, with the single processing stage between the two; the
// output register lets a new request in while a result waits.
module scrolling_seven_segment_driver_top
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    ssd_req_if.sink             req,
    ssd_res_if.source           res,
    input  logic                cfg_wr_en,
    input  logic [PERIOD_W-1:0] cfg_wr_data
);

    // configuration
    logic [PERIOD_W-1:0] period_reg;

    // input register
    logic                in_vld_reg;
    logic                in_type_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_first_reg;

    // output register
    logic                out_vld_reg;
    logic [SEG_W-1:0]    out_seg_reg;
    logic [ENA_W-1:0]    out_ena_reg;

    logic                has_result;
    logic                fire;
    logic                tick_en;
    logic                load_en;
    store_stat_t         stat;
    logic [ADDR_W-1:0]   rd_addr;
    glyph_t              rd_glyph;
    logic [SEG_W-1:0]    segments_next;
    logic [ENA_W-1:0]    enable_n_next;

    // a tick only yields a result when no string is loading
    assign has_result = (in_type_reg == REQ_TICK) && !stat.loading;
    // the held request moves on unless its result would find the output full
    assign fire       = in_vld_reg && (!has_result || !out_vld_reg || res.ready);
    assign tick_en    = fire && has_result;
    assign load_en    = fire && (in_type_reg == REQ_LOAD);
    assign req.ready  = !in_vld_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= SCROLL_PERIOD_RST;
        end
        else if (cfg_wr_en)
        begin
            period_reg <= cfg_wr_data;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_vld_reg <= req.valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_type_reg  <= req.req_type;
            in_char_reg  <= req.char_code;
            in_first_reg <= req.first;
        end
    end

    ssd_glyph_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_en   (load_en),
        .first     (in_first_reg),
        .char_code (in_char_reg),
        .rd_addr   (rd_addr),
        .rd_glyph  (rd_glyph),
        .stat      (stat)
    );

    ssd_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_en),
        .period        (period_reg),
        .stat          (stat),
        .rd_addr       (rd_addr),
        .rd_glyph      (rd_glyph),
        .segments_next (segments_next),
        .enable_n_next (enable_n_next)
    );

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (tick_en)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (tick_en)
        begin
            out_seg_reg <= segments_next;
            out_ena_reg <= enable_n_next;
        end
    end

    assign res.valid          = out_vld_reg;
    assign res.segments       = out_seg_reg;
    assign res.digit_enable_n = out_ena_reg;

endmodule
